@@ hdl/set_assoc_cache_access_model_macros.svh @@
// assertion macros for the set-associative cache access model
// used by the port checker; no other dependencies
`ifndef SET_ASSOC_CACHE_ACCESS_MODEL_MACROS_SVH
`define SET_ASSOC_CACHE_ACCESS_MODEL_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sac_pkg.sv @@
// shared types and constants of the set-associative cache access model
// no dependencies
package sac_pkg;

    localparam int TAG_W   = 30;
    localparam int STAMP_W = 48;
    localparam int CNT_W   = 32;
    localparam int CYC_W   = 16;
    localparam int IDXV_W  = 15;  // widest masked index value (index_bits up to 15)
    localparam int CFG_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [STAMP_W-1:0] TOTAL_MAX = {STAMP_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CYC_W-1:0]   WORD_WRITE = 16'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_ALLOC    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_THROUGH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU     = 3'd5;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // one way of a set
    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] astamp;
        logic [STAMP_W-1:0] lstamp;
    } way_t;

    // access outcome handed to the cost unit
    typedef struct packed {
        logic store;
        logic hit;
        logic no_alloc;
        logic wr_through;
        logic dirty_victim;
    } sac_ctl_t;

endpackage

@@ hdl/set_assoc_cache_access_model.sv @@
// top level of the set-associative cache access model
// depends on sac_pkg and sac_cost
//
// Usage: requests enter on in_valid/in_ready (operation, address); one result
// per request leaves on out_valid/out_ready through an output register.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle.
// Each set is one row of a synchronous memory holding all ways; a per-set
// valid flop marks rows never written, so no clearing pass is needed.
// From acceptance to result, with W = ways in use (1..WAYS): the address is split
// as the request is accepted, the index is reduced by SETS in the multiply and
// modulo states, the set row is read, W ways are victim-scanned (one way per
// cycle), and the update state writes the row back and loads the output register.
// The block does not take a new request before the last one is through, as the
// set row is read, modified and written back per request. in_ready is high
// only while no request is in flight.
// If the receiver stalls, the finished result holds in the output register
// and the update waits until it is taken. Reset empties the cache, zeroes the
// cycle total and counters and loads the default configuration.
module set_assoc_cache_access_model #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sac_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sac_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [31:0]                       address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic                              wrote_back,
    output logic [sac_pkg::CYC_W-1:0]         access_cycles,
    output logic [sac_pkg::STAMP_W-1:0]       run_total,
    output logic [sac_pkg::CNT_W-1:0]         load_hit_count,
    output logic [sac_pkg::CNT_W-1:0]         load_miss_count,
    output logic [sac_pkg::CNT_W-1:0]         store_hit_count,
    output logic [sac_pkg::CNT_W-1:0]         store_miss_count
);
    import sac_pkg::*;

    localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW = $clog2(WAYS + 1);
    localparam int RB_W = 33;
    localparam logic [RB_W-1:0] RECIP = RB_W'((64'd1 << 32) / SETS);
    localparam int PROD_W = IDXV_W + RB_W;

    typedef way_t [WAYS-1:0] row_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_MOD  = 6'b000100,
        ST_RD   = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_UPD  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [3:0] index_bits_reg, offset_bits_reg;
    logic [2:0] ways_reg;
    logic       wr_alloc_reg, wr_through_reg, use_lru_reg;

    // request registers
    logic                 op_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [IDXV_W-1:0]    idxv_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SW-1:0]        set_reg;
    logic [WW-1:0]        way_reg;
    logic                 inv_found_reg;
    logic [WW-1:0]        vic_reg;
    logic [STAMP_W-1:0]   best_reg;

    // storage
    row_t                 row_mem [SETS];
    row_t                 rd_row_reg;
    logic [SETS-1:0]      row_ok_bits_reg;
    logic                 row_ok_reg;
    logic                 rd_en, wr_en;
    row_t                 wr_row;

    // running state
    logic [STAMP_W-1:0]   total_reg;
    logic [CNT_W-1:0]     cnt_reg [4];

    // output register
    logic                 out_valid_reg;
    logic                 hit_reg, wb_reg;
    logic [CYC_W-1:0]     cyc_reg;

    // address split
    logic [3:0]           off_c;
    logic [4:0]           tag_shift;
    logic [31:0]          addr_off;
    logic [31:0]          addr_tag;
    logic [IDXV_W-1:0]    idx_mask;
    logic [NW-1:0]        n_c;

    // reduction by SETS
    logic [RB_W-1:0]      quot;
    logic [RB_W-1:0]      rem_w;
    logic [RB_W-1:0]      rem_c;

    // lookup
    logic                 hit_c;
    logic [WW-1:0]        hit_way;
    way_t                 scan_way;
    logic [STAMP_W-1:0]   scan_stamp;
    logic                 last_way;
    logic [WW-1:0]        pick;
    logic                 upd_go;
    sac_ctl_t             ctl;
    logic [CYC_W-1:0]     charged;
    logic [STAMP_W-1:0]   total_new;
    logic [STAMP_W-1:0]   stamp;
    logic [1:0]           cnt_sel;

    // clamped configuration
    always_comb
    begin
        off_c = offset_bits_reg;
        if (offset_bits_reg < 4'd2)
        begin
            off_c = 4'd2;
        end
        else if (offset_bits_reg > 4'd10)
        begin
            off_c = 4'd10;
        end
        if (ways_reg == 3'd0)
        begin
            n_c = NW'(1);
        end
        else if (int'(ways_reg) > WAYS)
        begin
            n_c = NW'(WAYS);
        end
        else
        begin
            n_c = NW'(ways_reg);
        end
    end

    assign tag_shift = {1'b0, index_bits_reg} + {1'b0, off_c};
    assign addr_off  = address >> off_c;
    assign addr_tag  = address >> tag_shift;
    assign idx_mask  = ~({IDXV_W{1'b1}} << index_bits_reg);

    // index modulo SETS: reciprocal quotient, then one correcting subtract
    assign quot  = RB_W'(prod_reg[PROD_W-1:32]);
    assign rem_w = RB_W'(idxv_reg) - RB_W'(quot * RB_W'(SETS));
    assign rem_c = (rem_w >= RB_W'(SETS)) ? rem_w - RB_W'(SETS) : rem_w;

    // parallel tag match over used ways, lowest way first
    always_comb
    begin
        hit_c   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_c && (w < int'(n_c)) && row_ok_reg && rd_row_reg[w].valid &&
                (rd_row_reg[w].tag == tag_reg))
            begin
                hit_c   = 1'b1;
                hit_way = WW'(w);
            end
        end
    end

    // victim scan, one way per cycle
    assign scan_way   = rd_row_reg[way_reg];
    assign scan_stamp = use_lru_reg ? scan_way.astamp : scan_way.lstamp;
    assign last_way   = (int'(way_reg) == int'(n_c) - 1);

    assign upd_go = (state_reg == ST_UPD) && (!out_valid_reg || out_ready);

    // cost of the access
    assign ctl.store        = (op_reg == OP_STORE);
    assign ctl.hit          = hit_c;
    assign ctl.no_alloc     = (op_reg == OP_STORE) && !wr_alloc_reg;
    assign ctl.wr_through   = wr_through_reg;
    assign ctl.dirty_victim = !hit_c && !ctl.no_alloc && row_ok_reg &&
                              rd_row_reg[vic_reg].valid && rd_row_reg[vic_reg].dirty;

    sac_cost u_cost (
        .ctl       (ctl),
        .offset    (off_c),
        .total     (total_reg),
        .charged   (charged),
        .total_new (total_new),
        .stamp     (stamp)
    );

    assign pick    = hit_c ? hit_way : vic_reg;
    assign cnt_sel = {ctl.store, !hit_c};

    // modified row for write-back
    always_comb
    begin
        wr_row = rd_row_reg;
        if (!row_ok_reg)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                wr_row[w].valid = 1'b0;
                wr_row[w].dirty = 1'b0;
            end
        end
        if (hit_c)
        begin
            wr_row[pick].astamp = stamp;
            if (ctl.store && !ctl.no_alloc && !wr_through_reg)
            begin
                wr_row[pick].dirty = 1'b1;
            end
        end
        else
        begin
            wr_row[pick].valid  = 1'b1;
            wr_row[pick].dirty  = ctl.store && !wr_through_reg;
            wr_row[pick].tag    = tag_reg;
            wr_row[pick].astamp = stamp;
            wr_row[pick].lstamp = stamp;
        end
    end

    assign rd_en = (state_reg == ST_RD);
    assign wr_en = upd_go && !(ctl.no_alloc && !hit_c);

    // set memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= row_mem[set_reg];
        end
        if (wr_en)
        begin
            row_mem[set_reg] <= wr_row;
        end
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_MOD;
            ST_MOD:  state_next = ST_RD;
            ST_RD:   state_next = ST_SCAN;
            ST_SCAN: if (last_way) state_next = ST_UPD;
            ST_UPD:  if (upd_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            index_bits_reg  <= 4'd0;
            offset_bits_reg <= 4'd2;
            ways_reg        <= 3'd1;
            wr_alloc_reg    <= 1'b1;
            wr_through_reg  <= 1'b1;
            use_lru_reg     <= 1'b1;
            row_ok_bits_reg <= '0;
            total_reg       <= '0;
            for (int k = 0; k < 4; k++)
            begin
                cnt_reg[k] <= '0;
            end
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                    CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                    CFG_WAYS:        ways_reg        <= cfg_data[2:0];
                    CFG_WR_ALLOC:    wr_alloc_reg    <= cfg_data[0];
                    CFG_WR_THROUGH:  wr_through_reg  <= cfg_data[0];
                    CFG_USE_LRU:     use_lru_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (upd_go)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_new;
                if (cnt_reg[cnt_sel] != CNT_MAX)
                begin
                    cnt_reg[cnt_sel] <= cnt_reg[cnt_sel] + 1'b1;
                end
                if (wr_en)
                begin
                    row_ok_bits_reg[set_reg] <= 1'b1;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg   <= operation;
                tag_reg  <= addr_tag[TAG_W-1:0];
                idxv_reg <= addr_off[IDXV_W-1:0] & idx_mask;
            end
            ST_MUL:
            begin
                prod_reg <= PROD_W'(idxv_reg) * PROD_W'(RECIP);
            end
            ST_MOD:
            begin
                set_reg <= rem_c[SW-1:0];
            end
            ST_RD:
            begin
                row_ok_reg    <= row_ok_bits_reg[set_reg];
                way_reg       <= '0;
                inv_found_reg <= 1'b0;
                vic_reg       <= '0;
            end
            ST_SCAN:
            begin
                if (!inv_found_reg)
                begin
                    if (!(row_ok_reg && scan_way.valid))
                    begin
                        inv_found_reg <= 1'b1;
                        vic_reg       <= way_reg;
                    end
                    else if ((way_reg == '0) || (scan_stamp < best_reg))
                    begin
                        best_reg <= scan_stamp;
                        vic_reg  <= way_reg;
                    end
                end
                if (!last_way)
                begin
                    way_reg <= way_reg + 1'b1;
                end
            end
            ST_UPD:
            begin
                if (upd_go)
                begin
                    hit_reg <= hit_c;
                    wb_reg  <= ctl.dirty_victim;
                    cyc_reg <= charged;
                end
            end
            default: ;
        endcase
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign hit              = hit_reg;
    assign wrote_back       = wb_reg;
    assign access_cycles    = cyc_reg;
    assign run_total        = total_reg;
    assign load_hit_count   = cnt_reg[0];
    assign load_miss_count  = cnt_reg[1];
    assign store_hit_count  = cnt_reg[2];
    assign store_miss_count = cnt_reg[3];

endmodule

@@ hdl/sac_cost.sv @@
// cycle cost, saturating total and stamp value of one access
// depends on sac_pkg
module sac_cost (
    input  sac_pkg::sac_ctl_t                 ctl,
    input  logic [3:0]                        offset,
    input  logic [sac_pkg::STAMP_W-1:0]       total,
    output logic [sac_pkg::CYC_W-1:0]         charged,
    output logic [sac_pkg::STAMP_W-1:0]       total_new,
    output logic [sac_pkg::STAMP_W-1:0]       stamp
);
    import sac_pkg::*;

    logic [CYC_W-1:0]   xfer;
    logic [CYC_W-1:0]   tail;
    logic [STAMP_W:0]   sum_all;
    logic [STAMP_W:0]   sum_one;

    // block transfer cost, growing with the block size
    assign xfer = 16'd25 << offset;

    // cycles charged for this access
    always_comb
    begin
        tail = ctl.store ? (ctl.wr_through ? WORD_WRITE + 16'd1 : 16'd1) : 16'd2;
        if (ctl.no_alloc)
        begin
            charged = ctl.hit ? WORD_WRITE + 16'd1 : WORD_WRITE;
        end
        else if (ctl.hit)
        begin
            charged = (ctl.store && ctl.wr_through) ? WORD_WRITE + 16'd1 : 16'd1;
        end
        else
        begin
            charged = xfer + (ctl.dirty_victim ? xfer : 16'd0) + tail;
        end
    end

    // saturating totals
    assign sum_all = {1'b0, total} + {{(STAMP_W+1-CYC_W){1'b0}}, charged};
    assign sum_one = {1'b0, total} + {{STAMP_W{1'b0}}, 1'b1};
    assign total_new = sum_all[STAMP_W] ? TOTAL_MAX : sum_all[STAMP_W-1:0];

    // an allocating hit stamps the saturated old total plus one, all else the new total
    always_comb
    begin
        if (ctl.hit && !ctl.no_alloc)
        begin
            stamp = sum_one[STAMP_W] ? TOTAL_MAX : sum_one[STAMP_W-1:0];
        end
        else
        begin
            stamp = total_new;
        end
    end

endmodule

@@ hdl/sac_chk.sv @@
// port-level checker for the set-associative cache access model
// depends on sac_pkg and the assertion macros header
`include "set_assoc_cache_access_model_macros.svh"

module sac_chk (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          hit,
    input  logic                          wrote_back,
    input  logic [sac_pkg::CYC_W-1:0]     access_cycles,
    input  logic [sac_pkg::STAMP_W-1:0]   run_total
);
    import sac_pkg::*;

    // stalled result holds its total
    `SAC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(run_total), "stall moved")

    // one request in flight at a time
    `SAC_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

    // a hit never evicts a dirty block
    `SAC_ASSERT_NOW(a_hit_no_wb, out_valid && hit, !wrote_back, "write-back reported on a hit")

    // every access is charged a nonzero number of cycles
    `SAC_ASSERT_NOW(a_cost, out_valid, access_cycles != '0, "access charged zero cycles")

endmodule

bind set_assoc_cache_access_model sac_chk u_sac_chk (.*);

@@ tb/sv/set_assoc_cache_access_model_tb.sv @@
// self-checking testbench of the set-associative cache access model
// depends on sac_pkg and set_assoc_cache_access_model; keeps its own cache predictor
`timescale 1ns / 1ps

module set_assoc_cache_access_model_tb;
    import sac_pkg::*;

    localparam int NSETS     = 256;
    localparam int NWAYS     = 4;
    localparam int NENTRIES  = NSETS * NWAYS;
    localparam int LIMIT     = 1000000;
    localparam int SETTLE    = 24;
    localparam logic [47:0] TOT_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        hit;
        logic        wb;
        logic [15:0] acc;
        logic [47:0] tot;
        logic [31:0] ld_hit;
        logic [31:0] ld_miss;
        logic [31:0] st_hit;
        logic [31:0] st_miss;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic [31:0] address = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit, wrote_back;
    logic [CYC_W-1:0] access_cycles;
    logic [STAMP_W-1:0] run_total;
    logic [CNT_W-1:0] load_hit_count, load_miss_count, store_hit_count, store_miss_count;

    set_assoc_cache_access_model u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .address(address),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .wrote_back(wrote_back), .access_cycles(access_cycles),
        .run_total(run_total), .load_hit_count(load_hit_count),
        .load_miss_count(load_miss_count),
        .store_hit_count(store_hit_count), .store_miss_count(store_miss_count)
    );

    // predictor state
    logic [3:0]  cur_ib, cur_ob;
    logic [2:0]  cur_ways;
    logic        cur_wa, cur_wt, cur_lru;
    logic [29:0] way_tag [NENTRIES];
    logic        way_valid [NENTRIES];
    logic        way_dirty [NENTRIES];
    logic [47:0] way_astamp [NENTRIES];
    logic [47:0] way_lstamp [NENTRIES];
    logic [47:0] cycle_sum;
    logic [31:0] hm_count [4];
    logic [31:0] charged;

    access_result_t pending_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int phases_run = 0;
    int cycle_cnt = 0;
    int snd_idle = 0;
    int rcv_stall = 0;

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rcv_stall);
    end

    // add cycles to the running total, saturating
    task automatic add_cycles(input logic [31:0] c);
        logic [48:0] s;
        begin
            s = {1'b0, cycle_sum} + {17'd0, c};
            cycle_sum = s[48] ? TOT_SAT : s[47:0];
            charged = charged + c;
        end
    endtask

    task automatic count_up(input int k);
        begin
            if (hm_count[k] != CNT_SAT)
                hm_count[k] = hm_count[k] + 32'd1;
        end
    endtask

    function automatic int choose_victim(input int base, input int n);
        int v;
        logic [47:0] se, sv;
        begin
            v = 0;
            for (int w = 0; w < n; w++)
            begin
                if (!way_valid[base + w])
                    return w;
                se = cur_lru ? way_astamp[base + w] : way_lstamp[base + w];
                sv = cur_lru ? way_astamp[base + v] : way_lstamp[base + v];
                if (se < sv)
                    v = w;
            end
            return v;
        end
    endfunction

    // work out the result of one access and update the predicted cache
    task automatic cache_access(input logic op, input logic [31:0] addr,
                                output access_result_t r);
        int off, ib, n, base, e;
        logic [31:0] set_v, tag_v, xfer;
        logic is_store, is_hit, wb;
        begin
            is_store = (op == OP_STORE);
            off = int'(cur_ob);
            ib = int'(cur_ib);
            n = int'(cur_ways);
            if (off < 2) off = 2;
            if (off > 10) off = 10;
            if (n < 1) n = 1;
            if (n > NWAYS) n = NWAYS;
            xfer = 32'd25 << off;
            set_v = ((addr >> off) & ((32'd1 << ib) - 32'd1)) % NSETS;
            tag_v = (addr >> (ib + off)) & 32'h3FFF_FFFF;
            base = int'(set_v) * NWAYS;
            charged = 0;
            is_hit = 1'b0;
            wb = 1'b0;
            e = 0;
            for (int w = 0; w < n; w++)
            begin
                if (!is_hit && way_valid[base + w] && way_tag[base + w] == tag_v[29:0])
                begin
                    is_hit = 1'b1;
                    e = base + w;
                end
            end
            if (is_store && !cur_wa)
            begin
                if (is_hit)
                begin
                    count_up(2);
                    add_cycles(32'd1);
                    add_cycles(32'(WORD_WRITE));
                    way_astamp[e] = cycle_sum;
                end
                else
                begin
                    count_up(3);
                    add_cycles(32'(WORD_WRITE));
                end
            end
            else if (is_hit)
            begin
                count_up(is_store ? 2 : 0);
                add_cycles(32'd1);
                way_astamp[e] = cycle_sum;
                if (is_store)
                begin
                    if (cur_wt)
                        add_cycles(32'(WORD_WRITE));
                    else
                        way_dirty[e] = 1'b1;
                end
            end
            else
            begin
                count_up(is_store ? 3 : 1);
                add_cycles(xfer);
                e = base + choose_victim(base, n);
                if (way_valid[e] && way_dirty[e])
                begin
                    add_cycles(xfer);
                    wb = 1'b1;
                end
                way_tag[e] = tag_v[29:0];
                way_valid[e] = 1'b1;
                way_dirty[e] = 1'b0;
                if (!is_store)
                    add_cycles(32'd2);
                else if (cur_wt)
                begin
                    add_cycles(32'd1);
                    add_cycles(32'(WORD_WRITE));
                end
                else
                begin
                    add_cycles(32'd1);
                    way_dirty[e] = 1'b1;
                end
                way_astamp[e] = cycle_sum;
                way_lstamp[e] = cycle_sum;
            end
            r.hit = is_hit;
            r.wb = wb;
            r.acc = charged[15:0];
            r.tot = cycle_sum;
            r.ld_hit = hm_count[0];
            r.ld_miss = hm_count[1];
            r.st_hit = hm_count[2];
            r.st_miss = hm_count[3];
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        access_result_t exp_r, got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hit, wrote_back, access_cycles, run_total,
                    load_hit_count, load_miss_count, store_hit_count, store_miss_count};
            results_seen++;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on result %0d:\n  exp %p\n  got %p",
                                 results_seen, exp_r, got);
                end
            end
        end
    end

    // send one request, idling first at random
    task automatic send_request(input logic op, input logic [31:0] addr);
        access_result_t r;
        begin
            @(negedge clk);
            while ($urandom_range(99) < snd_idle)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid = 1'b1;
            operation = op;
            address = addr;
            do
                @(posedge clk);
            while (!in_ready);
            cache_access(op, addr, r);
            pending_q.push_back(r);
            items_sent++;
        end
    endtask

    task automatic stop_sending;
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // wait until every result is in and the block has settled
    task automatic wait_drain;
        begin
            while (pending_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        begin
            @(negedge clk);
            cfg_write = 1'b1;
            cfg_index = idx;
            cfg_data = val;
            case (idx)
                CFG_INDEX_BITS:  cur_ib = val;
                CFG_OFFSET_BITS: cur_ob = val;
                CFG_WAYS:        cur_ways = val[2:0];
                CFG_WR_ALLOC:    cur_wa = val[0];
                CFG_WR_THROUGH:  cur_wt = val[0];
                CFG_USE_LRU:     cur_lru = val[0];
                default: ;
            endcase
            @(negedge clk);
            cfg_write = 1'b0;
        end
    endtask

    // idle, then write the whole configuration
    task automatic load_config(input logic [3:0] ib, input logic [3:0] ob,
                               input logic [3:0] nw, input logic wa,
                               input logic wt, input logic lru);
        begin
            stop_sending();
            wait_drain();
            write_reg(CFG_INDEX_BITS, ib);
            write_reg(CFG_OFFSET_BITS, ob);
            write_reg(CFG_WAYS, nw);
            write_reg(CFG_WR_ALLOC, {3'b0, wa});
            write_reg(CFG_WR_THROUGH, {3'b0, wt});
            write_reg(CFG_USE_LRU, {3'b0, lru});
            phases_run++;
        end
    endtask

    // extremes, both access kinds and the special cases
    task automatic test_directed;
        begin
            // defaults after reset: one set, one way, write-through
            send_request(OP_LOAD, 32'h0000_0000);
            send_request(OP_LOAD, 32'h0000_0003);
            send_request(OP_STORE, 32'hFFFF_FFFF);
            send_request(OP_STORE, 32'hFFFF_FFFC);
            // offset below range clamps to 2, index wider than the set count
            load_config(4'd15, 4'd0, 4'd0, 1'b1, 1'b0, 1'b1);
            send_request(OP_STORE, 32'h1234_5678);
            send_request(OP_STORE, 32'h1234_5678);
            // dirty victim written back by a load miss
            send_request(OP_LOAD, 32'h9234_5678);
            send_request(OP_STORE, 32'h5234_5678);
            // dirty victim left over, now write-through
            load_config(4'd15, 4'd0, 4'd7, 1'b1, 1'b1, 1'b0);
            send_request(OP_STORE, 32'hD234_5678);
            send_request(OP_LOAD, 32'h0000_0000);
            // offset above range clamps to 10, largest transfers
            load_config(4'd8, 4'd15, 4'd4, 1'b1, 1'b0, 1'b0);
            send_request(OP_STORE, 32'hFFFF_FFFF);
            send_request(OP_LOAD, 32'h7FFF_FFFF);
            send_request(OP_LOAD, 32'hBFFF_FFFF);
            send_request(OP_LOAD, 32'h3FFF_FFFF);
            send_request(OP_LOAD, 32'hDFFF_FFFF);
            send_request(OP_STORE, 32'h5FFF_FFFF);
            // no-write-allocate wins over write-back
            load_config(4'd0, 4'd10, 4'd1, 1'b0, 1'b0, 1'b1);
            send_request(OP_STORE, 32'h8000_0000);
            send_request(OP_LOAD, 32'h8000_0000);
            send_request(OP_STORE, 32'h8000_0001);
            send_request(OP_STORE, 32'h0000_0400);
        end
    endtask

    // sender waits for every result before the next request
    task automatic test_pressure;
        begin
            load_config(4'd2, 4'd2, 4'd2, 1'b1, 1'b0, 1'b1);
            for (int i = 0; i < 20; i++)
            begin
                send_request(1'($urandom_range(1)),
                             {2'($urandom_range(3)), 26'h0, 4'($urandom)});
                stop_sending();
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    // random phases of settings with access streams that reuse a few blocks
    task automatic test_random(input int phases, input int per_phase);
        logic [31:0] pool [8];
        logic [31:0] common, a;
        logic [3:0] ib, ob, nw;
        begin
            for (int p = 0; p < phases; p++)
            begin
                ib = 4'($urandom_range(8));
                ob = 4'($urandom_range(2, 6));
                nw = 4'($urandom_range(1, 4));
                if (p == 0) begin ib = 4'd0; ob = 4'd2; nw = 4'd1; end
                if (p == 1) begin ib = 4'd8; ob = 4'd10; nw = 4'd4; end
                if (p == 2) begin ib = 4'($urandom_range(15)); ob = 4'($urandom);
                    nw = 4'($urandom_range(7)); end
                load_config(ib, ob, nw, 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
                common = $urandom;
                for (int k = 0; k < 8; k++)
                    pool[k] = (k < 5) ? (($urandom & 32'hFFFF_0000) | (common & 32'hFFFF))
                                      : $urandom;
                for (int i = 0; i < per_phase; i++)
                begin
                    if ($urandom_range(99) < 75)
                        a = pool[3'($urandom_range(7))] ^ ($urandom & 32'h3);
                    else
                        a = $urandom;
                    send_request(1'($urandom_range(1)), a);
                end
            end
        end
    endtask

    initial
    begin
        cur_ib = 4'd0;
        cur_ob = 4'd2;
        cur_ways = 3'd1;
        cur_wa = 1'b1;
        cur_wt = 1'b1;
        cur_lru = 1'b1;
        cycle_sum = '0;
        for (int i = 0; i < 4; i++)
            hm_count[i] = '0;
        for (int i = 0; i < NENTRIES; i++)
        begin
            way_tag[i] = '0;
            way_valid[i] = 1'b0;
            way_dirty[i] = 1'b0;
            way_astamp[i] = '0;
            way_lstamp[i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        snd_idle = 32; rcv_stall = 53;
        test_directed();
        test_random(5, 90);
        snd_idle = 53; rcv_stall = 32;
        test_pressure();
        test_random(5, 90);
        snd_idle = 0; rcv_stall = 0;
        test_random(5, 90);

        stop_sending();
        wait_drain();
        $display("covered %0d accesses over %0d configuration phases, %0d results checked",
                 items_sent, phases_run, results_seen);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
